// ----- sv/cdq_pkg.sv -----
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared widths, operation and status codes and control types for the
// circular double-ended queue.
// ----------------------------------------------------------------------------
package cdq_pkg;

	// Payload and register widths
	localparam int DATA_W    = 32;
	localparam int OP_W      = 2;
	localparam int ST_W      = 2;
	localparam int CAP_W     = 6;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int DEPTH_DEF = 32;

	localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

	// Register index (byte address / 4)
	localparam logic REG_CAP = 1'b0;

	// Operation codes
	localparam logic [OP_W-1:0] OP_PUSH_REAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd1;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd2;
	localparam logic [OP_W-1:0] OP_POP_REAR   = 2'd3;

	// Result status codes
	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;   // capture the incoming item
		logic exec;   // carry out the captured operation
	} cdq_cmd_t;

endpackage

// ----- sv/cdq_if.sv -----
// ----------------------------------------------------------------------------
// cdq_in_if / cdq_out_if
// Valid/ready channels for operation items and result items.
// ----------------------------------------------------------------------------
interface cdq_in_if import cdq_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          opcode;
	logic signed [DATA_W-1:0] push_value;

	modport source (output valid, opcode, push_value, input ready);
	modport sink   (input valid, opcode, push_value, output ready);
endinterface

interface cdq_out_if import cdq_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [ST_W-1:0]          status;
	logic signed [DATA_W-1:0] pop_value;
	logic [CAP_W-1:0]         occupancy;

	modport source (output valid, status, pop_value, occupancy, input ready);
	modport sink   (input valid, status, pop_value, occupancy, output ready);
endinterface

// ----- sv/cdq_regs.sv -----
// ----------------------------------------------------------------------------
// cdq_regs
// APB register for the capacity in use; clamps it to the store depth and
// flags each write so the datapath can empty the queue.
// ----------------------------------------------------------------------------
module cdq_regs import cdq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output logic [CAP_W-1:0]   cap,
	output logic               clear
);

	logic [CAP_W-1:0] cap_q;
	logic             wr_en;
	logic             sel_cap;

	assign sel_cap = (paddr[2] == REG_CAP);
	assign wr_en   = psel && penable && pwrite && sel_cap;
	assign pready  = 1'b1;
	assign clear   = wr_en;

	// Hold the capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (wr_en) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	// Read back
	assign prdata = sel_cap ? {{(PDATA_W-CAP_W){1'b0}}, cap_q} : '0;

	// Clamp to 1..DEPTH
	always_comb begin
		if (cap_q == '0) begin
			cap = CAP_W'(1);
		end else if (32'(cap_q) > DEPTH) begin
			cap = CAP_W'(DEPTH);
		end else begin
			cap = cap_q;
		end
	end

endmodule

// ----- sv/cdq_ctrl.sv -----
// ----------------------------------------------------------------------------
// cdq_ctrl
// Sequencer: take an item, carry it out, then present the result until
// the receiver takes it.
// ----------------------------------------------------------------------------
module cdq_ctrl import cdq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output cdq_cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_OUT  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign cmd.load  = in_valid && in_ready;
	assign cmd.exec  = (state_q == S_EXEC);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_ready) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- sv/cdq_dp.sv -----
// ----------------------------------------------------------------------------
// cdq_dp
// Datapath: slot store, front and rear indices, entry count and the
// result registers.
// ----------------------------------------------------------------------------
module cdq_dp import cdq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cdq_cmd_t                 cmd,
	input  logic                     clear,
	input  logic [CAP_W-1:0]         cap,
	input  logic [OP_W-1:0]          opcode,
	input  logic [DATA_W-1:0]        push_value,
	output logic [ST_W-1:0]          status,
	output logic [DATA_W-1:0]        pop_value,
	output logic [CAP_W-1:0]         occupancy
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = ((IDX_W > CAP_W) ? IDX_W : CAP_W) + 1;

	logic [DATA_W-1:0] mem [DEPTH];

	logic [OP_W-1:0]   op_q;
	logic [DATA_W-1:0] val_q;
	logic [IDX_W-1:0]  front_q, rear_q;
	logic [CAP_W-1:0]  count_q;
	logic [ST_W-1:0]   status_q;
	logic              pop_ok_q;
	logic [DATA_W-1:0] rd_data_q;

	logic [IDX_W-1:0]  front_d, rear_d;
	logic [CAP_W-1:0]  count_d;
	logic [ST_W-1:0]   status_d;
	logic              pop_ok_d;
	logic              we, re;
	logic [IDX_W-1:0]  waddr, raddr;

	logic [CW-1:0]     cap_x;
	logic [IDX_W-1:0]  front_inc, front_dec, rear_inc, rear_dec, last_idx;

	// Wrap arithmetic on the indices
	assign cap_x     = CW'(cap);
	assign last_idx  = IDX_W'(cap_x - CW'(1));
	assign front_inc = (CW'(front_q) + CW'(1) == cap_x) ? '0 : front_q + IDX_W'(1);
	assign rear_inc  = (CW'(rear_q) + CW'(1) == cap_x) ? '0 : rear_q + IDX_W'(1);
	assign front_dec = (front_q == '0) ? last_idx : front_q - IDX_W'(1);
	assign rear_dec  = (rear_q == '0) ? last_idx : rear_q - IDX_W'(1);

	// Operation decode and state update
	always_comb begin
		front_d  = front_q;
		rear_d   = rear_q;
		count_d  = count_q;
		status_d = ST_OK;
		pop_ok_d = 1'b0;
		we       = 1'b0;
		re       = 1'b0;
		waddr    = '0;
		raddr    = rear_q;
		case (op_q)
			OP_PUSH_REAR, OP_PUSH_FRONT: begin
				if (count_q == '0) begin
					front_d = '0;
					rear_d  = '0;
					count_d = CAP_W'(1);
					we      = 1'b1;
				end else if (count_q == cap) begin
					status_d = ST_FULL;
				end else if (op_q == OP_PUSH_REAR) begin
					rear_d  = rear_inc;
					waddr   = rear_inc;
					count_d = count_q + CAP_W'(1);
					we      = 1'b1;
				end else begin
					front_d = front_dec;
					waddr   = front_dec;
					count_d = count_q + CAP_W'(1);
					we      = 1'b1;
				end
			end
			OP_POP_FRONT, OP_POP_REAR: begin
				if (count_q == '0) begin
					status_d = ST_EMPTY;
				end else begin
					re       = 1'b1;
					pop_ok_d = 1'b1;
					raddr    = (op_q == OP_POP_FRONT) ? front_q : rear_q;
					count_d  = count_q - CAP_W'(1);
					if (count_q == CAP_W'(1)) begin
						front_d = '0;
						rear_d  = '0;
					end else if (op_q == OP_POP_FRONT) begin
						front_d = front_inc;
					end else begin
						rear_d = rear_dec;
					end
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	// Capture the item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= opcode;
			val_q <= push_value;
		end
	end

	// Advance indices and count; a capacity write empties the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			rear_q  <= '0;
			count_q <= '0;
		end else if (clear) begin
			front_q <= '0;
			rear_q  <= '0;
			count_q <= '0;
		end else if (cmd.exec) begin
			front_q <= front_d;
			rear_q  <= rear_d;
			count_q <= count_d;
		end
	end

	// Result registers
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q <= status_d;
			pop_ok_q <= pop_ok_d;
		end
	end

	// Slot store: write port
	always_ff @(posedge clk) begin
		if (cmd.exec && we) begin
			mem[waddr] <= val_q;
		end
	end

	// Slot store: registered read port
	always_ff @(posedge clk) begin
		if (cmd.exec && re) begin
			rd_data_q <= mem[raddr];
		end
	end

	assign status    = status_q;
	assign pop_value = pop_ok_q ? rd_data_q : '0;
	assign occupancy = count_q;

endmodule

// ----- sv/circular_deque.sv -----
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue in a circular slot store with a programmable capacity.
//
// in_ch carries one operation per item: opcode (push rear, push front,
// pop front, pop rear) and push_value. out_ch returns one result per item:
// status (ok, full, empty), pop_value (zero unless a pop succeeded) and
// occupancy after the operation.
// Each item passes the sequencer's accept, execute and present steps in
// turn: the execute step registers the result and uses the store's write
// port or its registered read port, and the present step offers the result.
// A new item is accepted only after out_ch has taken the last result.
// While out_ch stalls the result is held and no new item is accepted.
// The APB register capacity_in_use (address 0) sets the slots in use,
// 0 acting as 1 and values above DEPTH as DEPTH; every write empties the
// queue and must only happen while the block is idle.
// Reset empties the queue and sets the capacity to 32; slot contents are
// not cleared, since only written slots are ever read.
// ----------------------------------------------------------------------------
module circular_deque import cdq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	cdq_in_if.sink             in_ch,
	cdq_out_if.source          out_ch,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	cdq_cmd_t          cmd;
	logic [CAP_W-1:0]  cap;
	logic              clear;
	logic [DATA_W-1:0] pop_value;

	cdq_regs #(.DEPTH(DEPTH)) u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cap     (cap),
		.clear   (clear)
	);

	cdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd)
	);

	cdq_dp #(.DEPTH(DEPTH)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.clear      (clear),
		.cap        (cap),
		.opcode     (in_ch.opcode),
		.push_value (in_ch.push_value),
		.status     (out_ch.status),
		.pop_value  (pop_value),
		.occupancy  (out_ch.occupancy)
	);

	assign out_ch.pop_value = $signed(pop_value);

endmodule

// ----- sv/cdq_checker.sv -----
// ----------------------------------------------------------------------------
// cdq_checker
// Port-level checks on results of the circular deque, bound to the top.
// ----------------------------------------------------------------------------
module cdq_checker import cdq_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [ST_W-1:0]   status,
	input logic [DATA_W-1:0] pop_value,
	input logic [CAP_W-1:0]  occupancy
);

	// One item at a time: no new item right after one is taken
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("item accepted while another is in flight");

	// A refused push means the queue holds entries and yields zero
	a_full_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_FULL) |-> (occupancy != '0 && pop_value == '0))
		else $error("full status with empty queue or non-zero pop value");

	// A refused pop means the queue is empty and yields zero
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_EMPTY) |-> (occupancy == '0 && pop_value == '0))
		else $error("empty status with entries or non-zero pop value");

	// Hold a stalled result
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
			(out_valid && $stable(status) && $stable(pop_value) && $stable(occupancy)))
		else $error("stalled result changed");

endmodule

bind circular_deque cdq_checker u_cdq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.status    (out_ch.status),
	.pop_value (out_ch.pop_value),
	.occupancy (out_ch.occupancy)
);

// ----- tb/sv/tb_circular_deque.sv -----
// ----------------------------------------------------------------------------
// tb_circular_deque
// Self-checking bench for the circular double-ended queue. A short table of
// directed operations covers empty and full refusals, both ends, value
// extremes and out-of-range capacities. Random bursts leaning towards
// pushes or pops then fill and drain the queue under several capacities.
// Each result is checked against its table row or an in-bench queue model.
// ----------------------------------------------------------------------------
module tb_circular_deque import cdq_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	// One result item as the bench expects it
	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic [DATA_W-1:0] pop_value;
		logic [CAP_W-1:0]  occupancy;
	} outcome_t;

	typedef enum logic {STEP_OP, STEP_CAP} step_kind_t;

	// One row of the directed table
	typedef struct {
		step_kind_t        kind;
		logic [OP_W-1:0]   op;
		logic [DATA_W-1:0] value;
		bit                typed;
		outcome_t          want;
	} step_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata, prdata;

	cdq_in_if  in_ch ();
	cdq_out_if out_ch ();

	circular_deque dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Queue model state
	logic [DATA_W-1:0] slots [DEPTH_DEF];
	int unsigned       head_idx;
	int unsigned       tail_idx;
	bit                drained;
	logic [CAP_W-1:0]  cap_reg;

	outcome_t    pending [$];
	step_t       plan [$];
	int unsigned errors = 0;
	bit          quiet = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Capacity as the block applies it: 0 acts as 1, above DEPTH as DEPTH
	function automatic int unsigned live_cap();
		int unsigned c;
		c = cap_reg;
		if (c < 1) c = 1;
		if (c > DEPTH_DEF) c = DEPTH_DEF;
		return c;
	endfunction

	function automatic int unsigned held(input int unsigned c);
		if (drained) return 0;
		if (tail_idx >= head_idx) return tail_idx - head_idx + 1;
		return tail_idx + c - head_idx + 1;
	endfunction

	// Apply one operation to the model and return the result it yields
	function automatic outcome_t deque_step(input logic [OP_W-1:0] op,
			input logic [DATA_W-1:0] val);
		outcome_t    r;
		int unsigned c;
		c = live_cap();
		r = '0;
		r.status = ST_OK;
		if (op == OP_PUSH_REAR || op == OP_PUSH_FRONT) begin
			if (drained) begin
				// first entry always lands in slot 0, whichever end
				head_idx = 0;
				tail_idx = 0;
				drained = 1'b0;
				slots[0] = val;
			end else if (held(c) >= c) begin
				r.status = ST_FULL;
			end else if (op == OP_PUSH_REAR) begin
				tail_idx = (tail_idx + 1 == c) ? 0 : tail_idx + 1;
				slots[tail_idx] = val;
			end else begin
				head_idx = (head_idx == 0) ? c - 1 : head_idx - 1;
				slots[head_idx] = val;
			end
		end else begin
			if (drained) begin
				r.status = ST_EMPTY;
			end else begin
				r.pop_value = (op == OP_POP_FRONT) ? slots[head_idx] : slots[tail_idx];
				if (head_idx == tail_idx) begin
					head_idx = 0;
					tail_idx = 0;
					drained = 1'b1;
				end else if (op == OP_POP_FRONT) begin
					head_idx = (head_idx + 1 == c) ? 0 : head_idx + 1;
				end else begin
					tail_idx = (tail_idx == 0) ? c - 1 : tail_idx - 1;
				end
			end
		end
		r.occupancy = CAP_W'(held(c));
		return r;
	endfunction

	// Table builders
	task automatic add_op(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val);
		step_t s;
		s.kind = STEP_OP;
		s.op = op;
		s.value = val;
		s.typed = 1'b0;
		s.want = '0;
		plan.push_back(s);
	endtask

	task automatic add_chk(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val,
			input logic [ST_W-1:0] st, input logic [DATA_W-1:0] pv,
			input logic [CAP_W-1:0] occ);
		step_t s;
		s.kind = STEP_OP;
		s.op = op;
		s.value = val;
		s.typed = 1'b1;
		s.want.status = st;
		s.want.pop_value = pv;
		s.want.occupancy = occ;
		plan.push_back(s);
	endtask

	task automatic add_cap(input logic [CAP_W-1:0] v);
		step_t s;
		s.kind = STEP_CAP;
		s.op = OP_PUSH_REAR;
		s.value = DATA_W'(v);
		s.typed = 1'b0;
		s.want = '0;
		plan.push_back(s);
	endtask

	// Present one item, idling first at random; called at a falling edge
	task automatic offer(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val,
			input bit typed, input outcome_t want);
		outcome_t pred;
		while (!quiet && $urandom_range(99) < 38) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.opcode     <= op;
		in_ch.push_value <= val;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		pred = deque_step(op, val);
		pending.push_back(typed ? want : pred);
		@(negedge clk);
	endtask

	// Hold the sender until every result is back; ends at a falling edge
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	// Write the capacity register once the block is idle
	task automatic set_capacity(input logic [CAP_W-1:0] v);
		drain();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(4 * REG_CAP);
		pwdata  <= PDATA_W'(v);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		cap_reg  = v;
		head_idx = 0;
		tail_idx = 0;
		drained  = 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Random bursts leaning towards pushes or pops so the queue fills and empties
	task automatic run_phase(input int unsigned count);
		int unsigned       left;
		int unsigned       run_len;
		int unsigned       lean;
		logic [OP_W-1:0]   op;
		logic [DATA_W-1:0] val;
		outcome_t          none;
		none = '0;
		left = count;
		while (left > 0) begin
			run_len = $urandom_range(60, 4);
			case ($urandom_range(2))
				0:       lean = 85;
				1:       lean = 15;
				default: lean = 50;
			endcase
			for (int k = 0; k < run_len && left > 0; k++) begin
				if ($urandom_range(99) < lean)
					op = $urandom_range(1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
				else
					op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_REAR;
				case ($urandom_range(7))
					0:       val = 32'h8000_0000;
					1:       val = 32'h7FFF_FFFF;
					2:       val = '0;
					3:       val = '1;
					default: val = $urandom();
				endcase
				offer(op, val, 1'b0, none);
				left--;
			end
		end
	endtask

	// Randomise the receiver's readiness
	always @(negedge clk) begin
		out_ch.ready <= (quiet || !arst_n) ? 1'b1 : ($urandom_range(99) >= 38);
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending.size() == 0) begin
				$error("result with no item outstanding: status %0d pop_value %0h",
					out_ch.status, out_ch.pop_value);
				errors++;
			end else begin
				want = pending.pop_front();
				if (out_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, out_ch.status);
					errors++;
				end
				if (out_ch.pop_value !== want.pop_value) begin
					$error("pop_value: expected %0h, got %0h", want.pop_value,
						out_ch.pop_value);
					errors++;
				end
				if (out_ch.occupancy !== want.occupancy) begin
					$error("occupancy: expected %0d, got %0d", want.occupancy,
						out_ch.occupancy);
					errors++;
				end
			end
		end
	end

	// Stimulus and end of run
	initial begin
		logic [CAP_W-1:0] caps [9];
		arst_n           = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		in_ch.valid      = 1'b0;
		in_ch.opcode     = OP_PUSH_REAR;
		in_ch.push_value = '0;
		out_ch.ready     = 1'b1;
		cap_reg          = CAP_RESET;
		head_idx         = 0;
		tail_idx         = 0;
		drained          = 1'b1;

		// after reset: empty refusals, both ends, value extremes
		add_chk(OP_POP_FRONT,  32'h0,         ST_EMPTY, 32'h0,         6'd0);
		add_chk(OP_POP_REAR,   32'h1234_5678, ST_EMPTY, 32'h0,         6'd0);
		add_chk(OP_PUSH_REAR,  32'h7FFF_FFFF, ST_OK,    32'h0,         6'd1);
		add_chk(OP_PUSH_FRONT, 32'h8000_0000, ST_OK,    32'h0,         6'd2);
		add_op (OP_PUSH_REAR,  32'h0);
		add_op (OP_PUSH_FRONT, 32'hFFFF_FFFF);
		add_chk(OP_POP_FRONT,  32'h0,         ST_OK,    32'hFFFF_FFFF, 6'd3);
		add_chk(OP_POP_REAR,   32'h0,         ST_OK,    32'h0,         6'd2);
		add_chk(OP_POP_FRONT,  32'h0,         ST_OK,    32'h8000_0000, 6'd1);
		add_chk(OP_POP_REAR,   32'h0,         ST_OK,    32'h7FFF_FFFF, 6'd0);
		// single slot: full refusals at both ends
		add_cap(6'd1);
		add_chk(OP_PUSH_FRONT, 32'h5A5A_5A5A, ST_OK,    32'h0,         6'd1);
		add_chk(OP_PUSH_REAR,  32'h1,         ST_FULL,  32'h0,         6'd1);
		add_chk(OP_PUSH_FRONT, 32'h2,         ST_FULL,  32'h0,         6'd1);
		add_chk(OP_POP_REAR,   32'h0,         ST_OK,    32'h5A5A_5A5A, 6'd0);
		// capacity zero acts as one
		add_cap(6'd0);
		add_chk(OP_PUSH_REAR,  32'hA5A5_A5A5, ST_OK,    32'h0,         6'd1);
		add_chk(OP_PUSH_FRONT, 32'h3,         ST_FULL,  32'h0,         6'd1);
		add_chk(OP_POP_FRONT,  32'h0,         ST_OK,    32'hA5A5_A5A5, 6'd0);
		// capacity above DEPTH acts as DEPTH
		add_cap(6'd63);
		add_chk(OP_PUSH_FRONT, 32'h1,         ST_OK,    32'h0,         6'd1);
		add_op (OP_PUSH_FRONT, 32'h2);
		add_op (OP_POP_REAR,   32'h0);
		add_op (OP_POP_REAR,   32'h0);
		add_chk(OP_POP_FRONT,  32'h0,         ST_EMPTY, 32'h0,         6'd0);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// walk the directed table
		foreach (plan[i]) begin
			if (plan[i].kind == STEP_CAP)
				set_capacity(plan[i].value[CAP_W-1:0]);
			else
				offer(plan[i].op, plan[i].value, plan[i].typed, plan[i].want);
		end

		// random phases over several capacities, extremes included
		caps = '{6'd32, 6'd2, 6'd1, 6'd17, 6'd0, 6'd63, 6'd33, 6'd5,
			CAP_W'($urandom_range(31, 3))};
		foreach (caps[p]) begin
			set_capacity(caps[p]);
			quiet = (p == 3);
			run_phase(200);
			quiet = 1'b0;
		end

		// wait out the last results
		in_ch.valid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("tb_circular_deque OK");
		else
			$display("tb_circular_deque NOT OK");
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#5ms;
		$display("tb_circular_deque NOT OK");
		$finish;
	end

endmodule

// ----- circular_deque.f -----
sv/cdq_pkg.sv
sv/cdq_if.sv
sv/cdq_regs.sv
sv/cdq_ctrl.sv
sv/cdq_dp.sv
sv/circular_deque.sv
sv/cdq_checker.sv
tb/sv/tb_circular_deque.sv
